// ----- sv/hff_pkg.sv -----
package hff_pkg;

    // Field limits
    localparam int MAX_FIELD_DEF = 64;
    localparam int CNT_W         = 7;
    localparam int VALUE_W       = 32;
    localparam int S_TDATA_W     = 56;
    localparam int M_TDATA_W     = 40;

    // ASCII codes used in the field
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_X_LO   = 7'h78;
    localparam logic [6:0] CH_X_UP   = 7'h58;
    localparam logic [6:0] CH_A_LO   = 7'h61;
    localparam logic [6:0] CH_A_UP   = 7'h41;

    // Prefix countdown codes
    localparam logic [1:0] PRE_NONE  = 2'd0;
    localparam logic [1:0] PRE_X     = 2'd1;
    localparam logic [1:0] PRE_ZERO  = 2'd2;

    // Character counts of one field, in emit order
    typedef struct packed {
        logic [CNT_W-1:0]   lead;
        logic [1:0]         prefix;
        logic [CNT_W-1:0]   zeros;
        logic [3:0]         digits;
        logic [CNT_W-1:0]   trail;
        logic [CNT_W-1:0]   total;
        logic [VALUE_W-1:0] aligned;
    } layout_t;

    // Map one nibble to its hex digit
    function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [6:0] base;
        if (nib < 4'd10) begin
            hex_char = CH_ZERO + {3'b000, nib};
        end else begin
            base     = upper ? CH_A_UP : CH_A_LO;
            hex_char = base + {3'b000, nib} - 7'd10;
        end
    endfunction

endpackage

// ----- sv/hff_layout.sv -----
module hff_layout
    import hff_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
) (
    input  logic [VALUE_W-1:0] value,
    input  logic               alt_prefix,
    input  logic               left_justify,
    input  logic               zero_pad,
    input  logic               has_precision,
    input  logic [5:0]         precision,
    input  logic [6:0]         min_width,
    output layout_t            layout
);

    localparam logic [7:0] PREC_LIM  = 8'(MAX_FIELD - 2);
    localparam logic [7:0] WIDTH_LIM = 8'(MAX_FIELD);

    logic [7:0] prec_sat;
    logic [7:0] width_sat;
    logic [3:0] ndig;
    logic [7:0] npre;
    logic [7:0] nzero;
    logic [7:0] body;
    logic [7:0] pad;
    logic       zfill;
    logic [7:0] lead;
    logic [7:0] zeros;
    logic [7:0] trail;
    logic [7:0] total;
    logic [5:0] align_sh;

    // Count significant digits: highest nonzero nibble wins
    always_comb begin
        ndig = 4'd1;
        for (int i = 0; i < 8; i++) begin
            if (value[4*i +: 4] != 4'd0) begin
                ndig = 4'(i + 1);
            end
        end
        if (has_precision && precision == 6'd0 && value == '0) begin
            ndig = 4'd0;
        end
    end

    // Split the field into pad, prefix, zeros, digits
    always_comb begin
        prec_sat  = ({2'b00, precision} > PREC_LIM) ? PREC_LIM : {2'b00, precision};
        width_sat = ({1'b0, min_width} > WIDTH_LIM) ? WIDTH_LIM : {1'b0, min_width};
        npre      = (alt_prefix && value != '0) ? 8'd2 : 8'd0;
        nzero     = (has_precision && prec_sat > {4'd0, ndig}) ? prec_sat - {4'd0, ndig} : 8'd0;
        body      = {4'd0, ndig} + nzero + npre;
        pad       = (width_sat > body) ? width_sat - body : 8'd0;
        zfill     = !left_justify && zero_pad && !has_precision;
        lead      = (!left_justify && !zfill) ? pad : 8'd0;
        zeros     = nzero + (zfill ? pad : 8'd0);
        trail     = left_justify ? pad : 8'd0;
        total     = body + pad;
        align_sh  = {4'd8 - ndig, 2'b00};
    end

    assign layout.lead    = lead[CNT_W-1:0];
    assign layout.prefix  = npre[1:0];
    assign layout.zeros   = zeros[CNT_W-1:0];
    assign layout.digits  = ndig;
    assign layout.trail   = trail[CNT_W-1:0];
    assign layout.total   = total[CNT_W-1:0];
    assign layout.aligned = value << align_sh;

endmodule

// ----- sv/hex_field_formatter_top.sv -----
// Hex field formatter: printf-style %x / %X conversion of one 32-bit value.
// Input stream (s_*): one word per value with its flags, precision and width.
// Output stream (m_*): one word per ASCII character of the formatted field,
// m_tlast set on the final character, with the running character total.
// An item whose field is empty (zero value, precision zero, no width) gives
// no output word at all.
// Throughput: characters leave one per cycle while the receiver is ready,
// through a nibble shift register and a set of down counters; no new input
// word is taken until the last character of an item is emitted, and an empty
// field never leaves the idle state. Fields are at most MAX_FIELD characters.
// The first character reaches the output register after the field is loaded
// into the counters and the state register has moved to ST_RUN.
// A stalled receiver freezes the output register and the counters; the next
// input word may be taken while the final character still waits.
// Reset (aresetn low, synchronous) empties the output register, drops any
// field in progress and clears the character total to zero.
module hex_field_formatter_top
    import hff_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // value[31:0], upper_case[32], alt_prefix[33], left_justify[34],
    // zero_pad[35], has_precision[36], precision[42:37], min_width[49:43], zeros
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // character[6:0], chars_total[38:7], zero[39]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    lead_reg, lead_next;
    logic [1:0]          pre_reg, pre_next;
    logic [CNT_W-1:0]    zeros_reg, zeros_next;
    logic [3:0]          dig_reg, dig_next;
    logic [CNT_W-1:0]    trail_reg, trail_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic                upper_reg, upper_next;
    logic [VALUE_W-1:0]  count_reg, count_next;
    logic                mvalid_reg, mvalid_next;
    logic [6:0]          mchar_reg, mchar_next;
    logic                mlast_reg, mlast_next;
    logic [VALUE_W-1:0]  mtotal_reg, mtotal_next;

    layout_t             layout;
    logic                in_acc;
    logic                emit;
    logic [6:0]          char_sel;

    // Work out the field layout of the incoming word
    hff_layout #(
        .MAX_FIELD(MAX_FIELD)
    ) u_layout (
        .value        (s_tdata[31:0]),
        .alt_prefix   (s_tdata[33]),
        .left_justify (s_tdata[34]),
        .zero_pad     (s_tdata[35]),
        .has_precision(s_tdata[36]),
        .precision    (s_tdata[42:37]),
        .min_width    (s_tdata[49:43]),
        .layout       (layout)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign emit     = (state_reg == ST_RUN) && (!mvalid_reg || m_tready);

    // Pick the current character by phase
    always_comb begin
        if (lead_reg != '0) begin
            char_sel = CH_SPACE;
        end else if (pre_reg == PRE_ZERO) begin
            char_sel = CH_ZERO;
        end else if (pre_reg == PRE_X) begin
            char_sel = upper_reg ? CH_X_UP : CH_X_LO;
        end else if (zeros_reg != '0) begin
            char_sel = CH_ZERO;
        end else if (dig_reg != 4'd0) begin
            char_sel = hex_char(val_reg[VALUE_W-1 -: 4], upper_reg);
        end else begin
            char_sel = CH_SPACE;
        end
    end

    // Advance counters, shift digits, load output register
    always_comb begin
        state_next  = state_reg;
        lead_next   = lead_reg;
        pre_next    = pre_reg;
        zeros_next  = zeros_reg;
        dig_next    = dig_reg;
        trail_next  = trail_reg;
        rem_next    = rem_reg;
        val_next    = val_reg;
        upper_next  = upper_reg;
        count_next  = count_reg;
        mvalid_next = mvalid_reg;
        mchar_next  = mchar_reg;
        mlast_next  = mlast_reg;
        mtotal_next = mtotal_reg;

        if (m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    lead_next  = layout.lead;
                    pre_next   = layout.prefix;
                    zeros_next = layout.zeros;
                    dig_next   = layout.digits;
                    trail_next = layout.trail;
                    rem_next   = layout.total;
                    val_next   = layout.aligned;
                    upper_next = s_tdata[32];
                    if (layout.total != '0) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (emit) begin
                    if (lead_reg != '0) begin
                        lead_next = lead_reg - 1'b1;
                    end else if (pre_reg != PRE_NONE) begin
                        pre_next = pre_reg - 1'b1;
                    end else if (zeros_reg != '0) begin
                        zeros_next = zeros_reg - 1'b1;
                    end else if (dig_reg != 4'd0) begin
                        dig_next = dig_reg - 1'b1;
                        val_next = {val_reg[VALUE_W-5:0], 4'h0};
                    end else begin
                        trail_next = trail_reg - 1'b1;
                    end
                    rem_next    = rem_reg - 1'b1;
                    count_next  = count_reg + 1'b1;
                    mvalid_next = 1'b1;
                    mchar_next  = char_sel;
                    mlast_next  = (rem_reg == CNT_W'(1));
                    mtotal_next = count_reg + 1'b1;
                    if (rem_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        lead_reg   <= lead_next;
        pre_reg    <= pre_next;
        zeros_reg  <= zeros_next;
        dig_reg    <= dig_next;
        trail_reg  <= trail_next;
        rem_reg    <= rem_next;
        val_reg    <= val_next;
        upper_reg  <= upper_next;
        mchar_reg  <= mchar_next;
        mlast_reg  <= mlast_next;
        mtotal_reg <= mtotal_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {1'b0, mtotal_reg, mchar_reg};

endmodule

// ----- sv/hff_checker.sv -----
module hff_checker
    import hff_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast
);

    logic                out_acc;
    logic                seen_reg;
    logic [VALUE_W-1:0]  last_total_reg;
    logic [6:0]          ch;

    assign out_acc = m_tvalid && m_tready;
    assign ch      = m_tdata[6:0];

    // Track the total of the last word taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (out_acc) begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_acc) begin
            last_total_reg <= m_tdata[38:7];
        end
    end

    // An offered input word holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input word changed while waiting");

    // A stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // First word after reset carries a total of one
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && !seen_reg |-> m_tdata[38:7] == 32'd1)
        else $error("first character total is not one");

    // Totals advance by one per word taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && seen_reg |-> m_tdata[38:7] == last_total_reg + 32'd1)
        else $error("character total skipped or repeated");

    // Only pad, prefix and hex digit characters appear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (ch == CH_SPACE) || (ch == CH_X_LO) || (ch == CH_X_UP)
            || (ch >= 7'h30 && ch <= 7'h39) || (ch >= 7'h41 && ch <= 7'h46)
            || (ch >= 7'h61 && ch <= 7'h66))
        else $error("character outside the hex field set");

endmodule

bind hex_field_formatter_top hff_checker u_hff_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import hff_pkg::*;

    localparam int  CLK_PERIOD  = 20;
    localparam int  RESET_CYCLES = 8;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  SETTLE_CYCLES = 2 * MAX_FIELD_DEF + 16;
    localparam int  PREC_MAX    = MAX_FIELD_DEF - 2;
    localparam int  HOLD_CYCLES = 400;

    // One value with its conversion flags
    typedef struct packed {
        logic [6:0]  width;
        logic [5:0]  prec;
        logic        has_prec;
        logic        zpad;
        logic        left;
        logic        alt;
        logic        upper;
        logic [31:0] value;
    } hex_req_t;

    // One expected character word
    typedef struct {
        logic [6:0]  ch;
        logic        last;
        logic [31:0] total;
    } out_char_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    out_char_t   expected_chars[$];
    logic [31:0] char_total   = '0;
    int          error_count  = 0;
    int          chars_checked = 0;
    int          values_sent  = 0;
    int          empty_fields = 0;
    int          cycle_cnt    = 0;
    bit          tx_idle      = 1'b0;
    bit          rx_idle      = 1'b0;
    int          rx_hold      = 0;
    int          rx_stall     = 0;

    hex_field_formatter_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d characters outstanding",
                     cycle_cnt, expected_chars.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 8);
        return $urandom_range(9, 24);
    endfunction

    function automatic hex_req_t make_req(logic [31:0] v, logic up, logic alt, logic left,
                                          logic zp, logic hp, logic [5:0] p, logic [6:0] w);
        hex_req_t r;
        r.value    = v;
        r.upper    = up;
        r.alt      = alt;
        r.left     = left;
        r.zpad     = zp;
        r.has_prec = hp;
        r.prec     = p;
        r.width    = w;
        return r;
    endfunction

    // Build the formatted field and queue its characters with running totals
    task automatic predict_field(input hex_req_t r);
        int          prec;
        int          width;
        int          ndig;
        int          nzero;
        int          npre;
        int          body;
        int          pad;
        string       tab;
        byte         b;
        logic [3:0]  nib;
        logic [6:0]  fld[$];
        out_char_t   oc;
        prec  = (r.prec > PREC_MAX) ? PREC_MAX : int'(r.prec);
        width = (r.width > MAX_FIELD_DEF) ? MAX_FIELD_DEF : int'(r.width);
        ndig = 1;
        for (int i = 1; i < 8; i++) begin
            if ((r.value >> (4 * i)) != 0) ndig = i + 1;
        end
        if (r.has_prec && prec == 0 && r.value == 0) ndig = 0;
        npre  = (r.alt && r.value != 0) ? 2 : 0;
        nzero = (r.has_prec && prec > ndig) ? prec - ndig : 0;
        body  = ndig + nzero + npre;
        pad   = (width > body) ? width - body : 0;
        tab   = r.upper ? "0123456789ABCDEF" : "0123456789abcdef";

        if (!r.left && !(r.zpad && !r.has_prec)) begin
            repeat (pad) fld.push_back(CH_SPACE);
        end
        if (npre != 0) begin
            fld.push_back(CH_ZERO);
            fld.push_back(r.upper ? CH_X_UP : CH_X_LO);
        end
        if (!r.left && r.zpad && !r.has_prec) begin
            repeat (pad) fld.push_back(CH_ZERO);
        end
        repeat (nzero) fld.push_back(CH_ZERO);
        for (int i = 0; i < ndig; i++) begin
            nib = 4'(r.value >> (4 * (ndig - 1 - i)));
            b   = tab[nib];
            fld.push_back(b[6:0]);
        end
        if (r.left) begin
            repeat (pad) fld.push_back(CH_SPACE);
        end

        if (fld.size() == 0) empty_fields++;
        for (int k = 0; k < fld.size(); k++) begin
            char_total = char_total + 32'd1;
            oc.ch      = fld[k];
            oc.last    = (k == fld.size() - 1);
            oc.total   = char_total;
            expected_chars.push_back(oc);
        end
    endtask

    // Offer one word at the falling edge, hold until taken, then predict it
    task automatic send_value(input hex_req_t r);
        int gap;
        gap = (tx_idle && $urandom_range(0, 99) < 35) ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {{(S_TDATA_W - 50){1'b0}}, r};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_field(r);
        values_sent++;
        @(negedge aclk);
    endtask

    function automatic hex_req_t rand_req(bit big);
        hex_req_t r;
        int sel;
        r = hex_req_t'(50'({$urandom, $urandom}));
        sel = $urandom_range(0, 9);
        if (sel == 0) r.value = 32'h0;
        else if (sel < 3) r.value = $urandom_range(0, 255);
        else if (sel < 5) r.value = $urandom >> $urandom_range(0, 31);
        if (big) begin
            r.width = 7'($urandom_range(0, 127));
            r.prec  = 6'($urandom_range(0, 63));
        end else begin
            r.width = 7'($urandom_range(0, 16));
            r.prec  = 6'($urandom_range(0, 12));
        end
        return r;
    endfunction

    // Wait for every expected character, then for any field still in flight
    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver: long hold, random stalls, or always ready
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold  = rx_hold - 1;
            end else if (rx_stall > 0) begin
                m_tready = 1'b0;
                rx_stall = rx_stall - 1;
            end else if (rx_idle && $urandom_range(0, 99) < 25) begin
                m_tready = 1'b0;
                rx_stall = gap_len() - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Compare each character word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character word: tdata=%h tlast=%b", m_tdata, m_tlast);
                error_count++;
            end else begin
                automatic out_char_t oc = expected_chars.pop_front();
                chars_checked++;
                if (m_tdata[6:0] !== oc.ch) begin
                    $error("character: expected %h, actual %h", oc.ch, m_tdata[6:0]);
                    error_count++;
                end
                if (m_tlast !== oc.last) begin
                    $error("last: expected %b, actual %b", oc.last, m_tlast);
                    error_count++;
                end
                if (m_tdata[38:7] !== oc.total) begin
                    $error("chars_total: expected %0d, actual %0d", oc.total, m_tdata[38:7]);
                    error_count++;
                end
                if (m_tdata[39] !== 1'b0) begin
                    $error("pad bit: expected 0, actual %b", m_tdata[39]);
                    error_count++;
                end
            end
        end
    end

    // Flag extremes, saturation and the empty and prefix corner cases
    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_value(make_req(32'h0, 0, 0, 0, 0, 0, 6'd0, 7'd0));
        send_value(make_req(32'h0, 0, 0, 0, 0, 1, 6'd0, 7'd0));
        send_value(make_req(32'h0, 0, 0, 0, 0, 1, 6'd0, 7'd0));
        send_value(make_req(32'h0, 0, 1, 0, 0, 1, 6'd0, 7'd5));
        send_value(make_req(32'hffff_ffff, 0, 1, 0, 0, 0, 6'd0, 7'd0));
        send_value(make_req(32'hffff_ffff, 1, 1, 0, 0, 0, 6'd0, 7'd0));
        send_value(make_req(32'h0, 0, 1, 0, 0, 0, 6'd0, 7'd4));
        send_value(make_req(32'h0000_0abc, 1, 0, 0, 0, 1, 6'd63, 7'd0));
        send_value(make_req(32'h0000_0001, 0, 0, 0, 0, 0, 6'd0, 7'd127));
        send_value(make_req(32'h0000_002a, 0, 1, 0, 1, 0, 6'd0, 7'd10));
        send_value(make_req(32'h0000_002a, 0, 1, 1, 1, 0, 6'd0, 7'd10));
        send_value(make_req(32'h0000_002a, 1, 0, 0, 1, 1, 6'd4, 7'd10));
        send_value(make_req(32'hdead_beef, 1, 1, 1, 0, 0, 6'd0, 7'd12));
        send_value(make_req(32'hffff_ffff, 0, 1, 0, 0, 1, 6'd62, 7'd64));
        send_value(make_req(32'h8000_0000, 0, 0, 0, 0, 0, 6'd0, 7'd0));
        send_value(make_req(32'h0000_000f, 1, 0, 0, 0, 1, 6'd1, 7'd0));
        send_value(make_req(32'h0000_0005, 0, 0, 0, 0, 1, 6'd0, 7'd0));
        send_value(make_req(32'h0, 0, 1, 0, 1, 0, 6'd0, 7'd64));
        send_value(make_req(32'h1234_5678, 0, 0, 1, 0, 1, 6'd10, 7'd20));
        send_value(make_req(32'h0, 1, 1, 1, 1, 1, 6'd63, 7'd127));
        drain();
    endtask

    // Random values: an unbroken stretch first, then gaps on both sides
    task automatic test_random();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int n = 0; n < 228; n++) begin
            if (n == 40) begin
                tx_idle = 1'b1;
                rx_idle = 1'b1;
            end
            send_value(rand_req($urandom_range(0, 99) < 8));
        end
        drain();
    endtask

    // Stall the receiver for a long stretch while words keep coming
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_hold = HOLD_CYCLES;
        for (int n = 0; n < 12; n++) begin
            send_value(rand_req(n % 4 == 0));
        end
        tx_idle = 1'b1;
        drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_random();
        test_backpressure();

        $display("Sent %0d values (%0d empty fields), checked %0d characters,",
                 values_sent, empty_fields, chars_checked);
        $display("with saturated width and precision, all flags and a long output stall");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/hff_pkg.sv
sv/hff_layout.sv
sv/hex_field_formatter_top.sv
sv/hff_checker.sv
tb/sv/tb.sv
